// ----- design/csr_pkg.sv -----
package csr_pkg;

    localparam int VALUE_W = 10;
    localparam int INDEX_W = 10;
    localparam int RING_W  = 11;
    localparam int CMD_W   = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE   = 2'd0,
        CMD_READ    = 2'd1,
        CMD_REVERSE = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    localparam logic [RING_W-1:0] RING_RESET = 11'd1024;

endpackage

// ----- design/circular_segment_reverser.sv -----
// Ring store for a tour of up to TOUR_MAX entries with write, read and segment-reverse
// commands; each accepted word yields exactly one result word. The store is one
// synchronous memory with one write port and two read ports, and it is not cleared at
// reset: read only entries you have written. Write, unknown command, short segment and
// range errors reach the result register through FIN, a read through RD_WAIT and FIN, and
// a reverse of length L does floor(L/2) swaps in SWAP_LO and SWAP_HI before FIN, as every
// swap needs two writes through the single write port. The block takes one word at a time;
// the next word is accepted once the result has moved into the output register, even
// while that result still waits for m_ready. The user must write the ring size register
// through cfg_we/cfg_wdata only while the block is idle; the block does not enforce this.
// Values above TOUR_MAX act as TOUR_MAX and zero makes every index out of range.
module circular_segment_reverser
    import csr_pkg::*;
#(
    parameter int TOUR_MAX = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [RING_W-1:0]  cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [CMD_W-1:0]   s_command,
    input  logic [INDEX_W-1:0] s_index,
    input  logic [INDEX_W-1:0] s_end_index,
    input  logic [VALUE_W-1:0] s_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [VALUE_W-1:0] m_read_value,
    output logic               m_status
);

    localparam int AW = $clog2(TOUR_MAX);
    localparam int SW = $clog2(TOUR_MAX + 1);
    localparam int CW = (SW > RING_W) ? SW : RING_W;
    localparam logic [CW-1:0] MAX_CW = CW'(TOUR_MAX);

    typedef enum logic [2:0] {
        IDLE,
        RD_WAIT,
        SWAP_LO,
        SWAP_HI,
        FIN
    } state_t;

    state_t             state_reg;
    logic [RING_W-1:0]  ring_size_reg;
    logic [AW-1:0]      lo_reg;
    logic [AW-1:0]      hi_reg;
    logic [AW-1:0]      nm1_reg;
    logic [CW-1:0]      cnt_reg;
    logic [VALUE_W-1:0] res_value_reg;
    logic               res_status_reg;
    logic               m_valid_reg;
    logic [VALUE_W-1:0] m_read_value_reg;
    logic               m_status_reg;

    logic [VALUE_W-1:0] tour_mem [TOUR_MAX];
    logic [VALUE_W-1:0] rd_a_reg;
    logic [VALUE_W-1:0] rd_b_reg;

    logic               accept;
    cmd_t               cmd;
    logic [CW-1:0]      n_cw;
    logic [CW-1:0]      idx_cw;
    logic [CW-1:0]      end_cw;
    logic               idx_bad;
    logic               end_bad;
    logic [CW-1:0]      len_cw;
    logic [AW-1:0]      nm1;
    logic [AW-1:0]      lo_step;
    logic [AW-1:0]      hi_step;
    logic [CW-1:0]      cnt_dec;
    logic               out_free;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr_a;
    logic [AW-1:0]      mem_raddr_b;

    assign s_ready      = (state_reg == IDLE);
    assign accept       = s_valid && s_ready;
    assign cmd          = cmd_t'(s_command);
    assign m_valid      = m_valid_reg;
    assign m_read_value = m_read_value_reg;
    assign m_status     = m_status_reg;
    assign out_free     = !m_valid_reg || m_ready;

    always_comb begin
        n_cw    = (CW'(ring_size_reg) > MAX_CW) ? MAX_CW : CW'(ring_size_reg);
        idx_cw  = CW'(s_index);
        end_cw  = CW'(s_end_index);
        idx_bad = (idx_cw >= n_cw);
        end_bad = (end_cw >= n_cw);
        // A segment whose end lies before its start wraps past the last entry in use.
        if (idx_cw <= end_cw) begin
            len_cw = end_cw - idx_cw + CW'(1);
        end else begin
            len_cw = n_cw - idx_cw + end_cw + CW'(1);
        end
        nm1     = AW'(n_cw - CW'(1));
        lo_step = (lo_reg == nm1_reg) ? '0 : lo_reg + AW'(1);
        hi_step = (hi_reg == '0) ? nm1_reg : hi_reg - AW'(1);
        cnt_dec = cnt_reg - CW'(1);
    end

    always_comb begin
        mem_we      = 1'b0;
        mem_waddr   = idx_cw[AW-1:0];
        mem_wdata   = s_value;
        mem_re      = 1'b0;
        mem_raddr_a = idx_cw[AW-1:0];
        mem_raddr_b = end_cw[AW-1:0];
        case (state_reg)
            IDLE: begin
                if (accept) begin
                    case (cmd)
                        CMD_WRITE: mem_we = !idx_bad;
                        CMD_READ: mem_re = !idx_bad;
                        CMD_REVERSE: mem_re = !idx_bad && !end_bad && (len_cw > CW'(1));
                        default: mem_re = 1'b0;
                    endcase
                end
            end
            SWAP_LO: begin
                mem_we    = 1'b1;
                mem_waddr = lo_reg;
                mem_wdata = rd_b_reg;
            end
            SWAP_HI: begin
                // The next pair is fetched while the high end of this pair is written;
                // the two never share an address while swaps remain.
                mem_we      = 1'b1;
                mem_waddr   = hi_reg;
                mem_wdata   = rd_a_reg;
                mem_re      = (cnt_dec != '0);
                mem_raddr_a = lo_step;
                mem_raddr_b = hi_step;
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            tour_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_a_reg <= tour_mem[mem_raddr_a];
            rd_b_reg <= tour_mem[mem_raddr_b];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_size_reg <= RING_RESET;
        end else if (cfg_we) begin
            ring_size_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // In FIN a free output register is reloaded below instead.
            if (m_valid_reg && m_ready && state_reg != FIN) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                IDLE: begin
                    if (accept) begin
                        res_value_reg  <= '0;
                        lo_reg         <= idx_cw[AW-1:0];
                        hi_reg         <= end_cw[AW-1:0];
                        nm1_reg        <= nm1;
                        cnt_reg        <= len_cw >> 1;
                        case (cmd)
                            CMD_WRITE: begin
                                res_status_reg <= idx_bad ? STATUS_RANGE : STATUS_DONE;
                                state_reg      <= FIN;
                            end
                            CMD_READ: begin
                                res_status_reg <= idx_bad ? STATUS_RANGE : STATUS_DONE;
                                state_reg      <= idx_bad ? FIN : RD_WAIT;
                            end
                            CMD_REVERSE: begin
                                if (idx_bad || end_bad) begin
                                    res_status_reg <= STATUS_RANGE;
                                    state_reg      <= FIN;
                                end else if (len_cw > CW'(1)) begin
                                    res_status_reg <= STATUS_DONE;
                                    state_reg      <= SWAP_LO;
                                end else begin
                                    res_status_reg <= STATUS_DONE;
                                    state_reg      <= FIN;
                                end
                            end
                            default: begin
                                res_status_reg <= STATUS_DONE;
                                state_reg      <= FIN;
                            end
                        endcase
                    end
                end
                RD_WAIT: begin
                    res_value_reg <= rd_a_reg;
                    state_reg     <= FIN;
                end
                SWAP_LO: begin
                    state_reg <= SWAP_HI;
                end
                SWAP_HI: begin
                    cnt_reg <= cnt_dec;
                    lo_reg  <= lo_step;
                    hi_reg  <= hi_step;
                    if (cnt_dec == '0) begin
                        state_reg <= FIN;
                    end else begin
                        state_reg <= SWAP_LO;
                    end
                end
                FIN: begin
                    if (out_free) begin
                        m_valid_reg      <= 1'b1;
                        m_read_value_reg <= res_value_reg;
                        m_status_reg     <= res_status_reg;
                        state_reg        <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    a_swap_count_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SWAP_LO || state_reg == SWAP_HI) |-> (cnt_reg != '0))
        else $error("swap state entered with no swaps left");

    a_swap_in_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SWAP_LO) |-> (lo_reg <= nm1_reg && hi_reg <= nm1_reg))
        else $error("swap address beyond ring size");

    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr_a && mem_waddr != mem_raddr_b))
        else $error("read and write of the same entry in one cycle");

    a_read_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == RD_WAIT) |=> (state_reg == FIN && res_status_reg == STATUS_DONE))
        else $error("read did not complete as expected");

    a_result_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == FIN && out_free) |=> (m_valid_reg && state_reg == IDLE))
        else $error("result not delivered to output register");

endmodule

// ----- tb/tb_circular_segment_reverser.sv -----
module tb_circular_segment_reverser;
    import csr_pkg::*;

    localparam int TOUR_ENTRIES = 1024;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        logic               status;
    } ring_answer_t;

    typedef struct packed {
        logic [RING_W-1:0]  ring;
        cmd_t               cmd;
        logic [INDEX_W-1:0] idx;
        logic [INDEX_W-1:0] endi;
        logic [VALUE_W-1:0] val;
        logic               typed;
        logic [VALUE_W-1:0] rd;
        logic               st;
    } probe_t;

    // Rows with typed set carry their answer; the others are left to the ring mirror.
    localparam probe_t PROBES [25] = '{
        '{11'd1024, CMD_WRITE,   10'd0,    10'd0,    10'd0,    1'b1, 10'd0,    STATUS_DONE},
        '{11'd1024, CMD_WRITE,   10'd1,    10'd0,    10'd1023, 1'b1, 10'd0,    STATUS_DONE},
        '{11'd1024, CMD_WRITE,   10'd1022, 10'd1023, 10'd682,  1'b1, 10'd0,    STATUS_DONE},
        '{11'd1024, CMD_WRITE,   10'd1023, 10'd0,    10'd1023, 1'b1, 10'd0,    STATUS_DONE},
        '{11'd1024, CMD_READ,    10'd1023, 10'd0,    10'd0,    1'b1, 10'd1023, STATUS_DONE},
        '{11'd1024, CMD_READ,    10'd0,    10'd1023, 10'd1023, 1'b1, 10'd0,    STATUS_DONE},
        '{11'd1024, CMD_REVERSE, 10'd1022, 10'd1,    10'd0,    1'b0, 10'd0,    STATUS_DONE},
        '{11'd1024, CMD_READ,    10'd1022, 10'd0,    10'd0,    1'b0, 10'd0,    STATUS_DONE},
        '{11'd1024, CMD_READ,    10'd1,    10'd0,    10'd0,    1'b0, 10'd0,    STATUS_DONE},
        '{11'd1024, CMD_REVERSE, 10'd0,    10'd1,    10'd0,    1'b0, 10'd0,    STATUS_DONE},
        '{11'd1024, CMD_REVERSE, 10'd1,    10'd1,    10'd0,    1'b1, 10'd0,    STATUS_DONE},
        '{11'd1024, CMD_NONE,    10'd1023, 10'd1023, 10'd1023, 1'b1, 10'd0,    STATUS_DONE},
        '{11'd8,    CMD_WRITE,   10'd7,    10'd0,    10'd341,  1'b1, 10'd0,    STATUS_DONE},
        '{11'd8,    CMD_WRITE,   10'd8,    10'd0,    10'd5,    1'b1, 10'd0,    STATUS_RANGE},
        '{11'd8,    CMD_READ,    10'd1023, 10'd0,    10'd0,    1'b1, 10'd0,    STATUS_RANGE},
        '{11'd8,    CMD_REVERSE, 10'd7,    10'd8,    10'd0,    1'b1, 10'd0,    STATUS_RANGE},
        '{11'd8,    CMD_REVERSE, 10'd8,    10'd0,    10'd0,    1'b1, 10'd0,    STATUS_RANGE},
        '{11'd8,    CMD_REVERSE, 10'd7,    10'd0,    10'd0,    1'b0, 10'd0,    STATUS_DONE},
        '{11'd1,    CMD_READ,    10'd0,    10'd0,    10'd0,    1'b0, 10'd0,    STATUS_DONE},
        '{11'd1,    CMD_WRITE,   10'd1,    10'd0,    10'd9,    1'b1, 10'd0,    STATUS_RANGE},
        '{11'd1,    CMD_REVERSE, 10'd0,    10'd0,    10'd0,    1'b1, 10'd0,    STATUS_DONE},
        '{11'd0,    CMD_READ,    10'd0,    10'd0,    10'd0,    1'b1, 10'd0,    STATUS_RANGE},
        '{11'd0,    CMD_WRITE,   10'd0,    10'd0,    10'd77,   1'b1, 10'd0,    STATUS_RANGE},
        '{11'd2047, CMD_REVERSE, 10'd1023, 10'd0,    10'd0,    1'b0, 10'd0,    STATUS_DONE},
        '{11'd2047, CMD_READ,    10'd1023, 10'd0,    10'd0,    1'b0, 10'd0,    STATUS_DONE}
    };

    localparam logic [RING_W-1:0] PHASE_RING [8] = '{
        11'd1024, 11'd64, 11'd1, 11'd2, 11'd300, 11'd2047, 11'd17, 11'd1024
    };
    localparam int PHASE_ITEMS [8] = '{60, 90, 20, 30, 60, 60, 70, 50};

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               cfg_we      = 1'b0;
    logic [RING_W-1:0]  cfg_wdata   = RING_RESET;
    logic               s_valid     = 1'b0;
    logic               s_ready;
    logic [CMD_W-1:0]   s_command   = CMD_NONE;
    logic [INDEX_W-1:0] s_index     = '0;
    logic [INDEX_W-1:0] s_end_index = '0;
    logic [VALUE_W-1:0] s_value     = '0;
    logic               m_valid;
    logic               m_ready     = 1'b0;
    logic [VALUE_W-1:0] m_read_value;
    logic               m_status;

    logic [VALUE_W-1:0] ring_mirror [TOUR_ENTRIES];
    bit                 entry_set [TOUR_ENTRIES];
    logic [RING_W-1:0]  ring_size_cfg = RING_RESET;
    ring_answer_t       ring_answers_q [$];
    ring_answer_t       seen_word;
    ring_answer_t       due_word;

    int          fault_count   = 0;
    int          send_idle_pct = 25;
    int          recv_idle_pct = 88;
    bit          hold_request  = 1'b0;
    bit          hold_done     = 1'b0;
    int          hold_left     = 0;
    int unsigned cycle_count   = 0;

    circular_segment_reverser u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_index      (s_index),
        .s_end_index  (s_end_index),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .m_status     (m_status)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic int live_size();
        return (int'(ring_size_cfg) > TOUR_ENTRIES) ? TOUR_ENTRIES : int'(ring_size_cfg);
    endfunction

    function automatic ring_answer_t ring_apply(cmd_t cmd, logic [INDEX_W-1:0] idx,
                                                logic [INDEX_W-1:0] endi,
                                                logic [VALUE_W-1:0] val);
        int n;
        int lo;
        int hi;
        int span;
        logic [VALUE_W-1:0] held;
        ring_answer_t ans;
        n = live_size();
        lo = int'(idx);
        hi = int'(endi);
        ans.read_value = '0;
        ans.status = STATUS_DONE;
        case (cmd)
            CMD_WRITE: begin
                if (lo >= n) begin
                    ans.status = STATUS_RANGE;
                end else begin
                    ring_mirror[lo] = val;
                    entry_set[lo] = 1'b1;
                end
            end
            CMD_READ: begin
                if (lo >= n) ans.status = STATUS_RANGE;
                else ans.read_value = ring_mirror[lo];
            end
            CMD_REVERSE: begin
                if (lo >= n || hi >= n) begin
                    ans.status = STATUS_RANGE;
                end else begin
                    span = (lo <= hi) ? hi - lo + 1 : n - lo + hi + 1;
                    for (int k = 0; k < span / 2; k++) begin
                        held = ring_mirror[lo];
                        ring_mirror[lo] = ring_mirror[hi];
                        ring_mirror[hi] = held;
                        lo = (lo + 1 == n) ? 0 : lo + 1;
                        hi = (hi == 0) ? n - 1 : hi - 1;
                    end
                end
            end
            default: ;
        endcase
        return ans;
    endfunction

    // Picks an entry below n that has been written, so that reads never see an empty slot.
    function automatic int pick_set(int n);
        int at;
        for (int k = 0; k < 16; k++) begin
            at = $urandom_range(n - 1);
            if (entry_set[at]) return at;
        end
        at = $urandom_range(n - 1);
        for (int k = 0; k < n; k++) begin
            if (entry_set[(at + k) % n]) return (at + k) % n;
        end
        return 0;
    endfunction

    function automatic bit span_is_set(int lo, int span, int n);
        for (int k = 0; k < span; k++) begin
            if (!entry_set[(lo + k) % n]) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic offer_word(cmd_t cmd, logic [INDEX_W-1:0] idx, logic [INDEX_W-1:0] endi,
                              logic [VALUE_W-1:0] val, bit typed, ring_answer_t typed_ans);
        ring_answer_t ans;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_command   <= cmd;
        s_index     <= idx;
        s_end_index <= endi;
        s_value     <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        ans = ring_apply(cmd, idx, endi, val);
        if (typed) ans = typed_ans;
        ring_answers_q.push_back(ans);
    endtask

    // The ring size may only change once every word in flight has come back.
    task automatic settle_and_size(logic [RING_W-1:0] size);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (ring_answers_q.size() != 0) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= size;
        @(posedge aclk);
        cfg_we <= 1'b0;
        ring_size_cfg = size;
    endtask

    task automatic fill_ends(int n);
        for (int i = 0; i < n; i++) begin
            if ((i < 32 || i + 32 >= n) && !entry_set[i])
                offer_word(CMD_WRITE, INDEX_W'(i), INDEX_W'($urandom_range(1023)),
                           VALUE_W'($urandom_range(1023)), 1'b0, '0);
        end
    endtask

    task automatic random_item(int n);
        int roll;
        int lo;
        int hi;
        int span;
        cmd_t cmd;
        logic [INDEX_W-1:0] idx;
        logic [INDEX_W-1:0] endi;
        logic [VALUE_W-1:0] val;
        roll = $urandom_range(99);
        val  = VALUE_W'($urandom_range(1023));
        endi = INDEX_W'($urandom_range(1023));
        if (n < TOUR_ENTRIES && roll < 8) begin
            cmd = cmd_t'($urandom_range(2));
            idx = INDEX_W'($urandom_range(TOUR_ENTRIES - 1, n));
            if (cmd == CMD_REVERSE && $urandom_range(1) == 1) begin
                endi = idx;
                idx  = INDEX_W'($urandom_range(n - 1));
            end
        end else if (roll < 12) begin
            cmd = CMD_NONE;
            idx = INDEX_W'($urandom_range(1023));
        end else if (roll < 42) begin
            cmd = CMD_WRITE;
            idx = INDEX_W'($urandom_range(n - 1));
        end else if (roll < 67) begin
            cmd = CMD_READ;
            idx = INDEX_W'(pick_set(n));
        end else begin
            cmd = CMD_REVERSE;
            lo  = pick_set(n);
            hi  = lo;
            for (int tries = 0; tries < 8; tries++) begin
                span = $urandom_range((n < 64) ? n : 64, 1);
                if (span_is_set(lo, span, n)) begin
                    hi = (lo + span - 1) % n;
                    break;
                end
            end
            idx  = INDEX_W'(lo);
            endi = INDEX_W'(hi);
        end
        offer_word(cmd, idx, endi, val, 1'b0, '0);
    endtask

    initial begin
        ring_answer_t typed_word;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < 25; i++) begin
            if (PROBES[i].ring != ring_size_cfg) settle_and_size(PROBES[i].ring);
            typed_word.read_value = PROBES[i].rd;
            typed_word.status     = PROBES[i].st;
            offer_word(PROBES[i].cmd, PROBES[i].idx, PROBES[i].endi, PROBES[i].val,
                       PROBES[i].typed, typed_word);
        end

        for (int p = 0; p < 8; p++) begin
            if (p == 3) begin
                send_idle_pct = 88;
                recv_idle_pct <= 25;
            end else if (p == 6) begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            settle_and_size(PHASE_RING[p]);
            // The hold-off starts only once the sender is about to offer words again.
            if (p == 6) hold_request <= 1'b1;
            fill_ends(live_size());
            for (int k = 0; k < PHASE_ITEMS[p]; k++) random_item(live_size());
        end

        s_valid <= 1'b0;
        while (ring_answers_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (fault_count == 0 && ring_answers_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // One long hold-off lets the sender fill the block until it stops taking words.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (hold_request && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= 400;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen_word.read_value = m_read_value;
            seen_word.status     = m_status;
            if (ring_answers_q.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_MAX)
                    $display("unexpected result word: read_value %0d status %0d",
                             seen_word.read_value, seen_word.status);
            end else begin
                due_word = ring_answers_q.pop_front();
                if (seen_word.read_value !== due_word.read_value ||
                    seen_word.status !== due_word.status) begin
                    fault_count++;
                    if (fault_count <= REPORT_MAX)
                        $display("mismatch: read_value %0d (want %0d) status %0d (want %0d)",
                                 seen_word.read_value, due_word.read_value,
                                 seen_word.status, due_word.status);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule
